>>> rtl/tef_pkg.sv
// ----------------------------------------------------------------------------
// tef_pkg - shared types and constants of the tracking error fuzzifier
// Widths, ramp constants, the distance membership table and the data word
// that walks down the square root cell chain.
// ----------------------------------------------------------------------------
package tef_pkg;

   // field widths
   localparam int POS_BITS  = 16;
   localparam int FRAC_BITS = 15;
   localparam int HEAD_BITS = 15;
   localparam int HERR_W    = HEAD_BITS + 1;
   localparam int DIST_W    = POS_BITS + 1;
   localparam int MEM_W     = FRAC_BITS + 1;

   // full membership
   localparam logic [MEM_W-1:0] ONE = MEM_W'(1) << FRAC_BITS;

   // square root datapath
   localparam int ROOT_W    = DIST_W;
   localparam int SUM_W     = 2 * ROOT_W;
   localparam int REM_W     = ROOT_W + 2;
   localparam int NUM_CELLS = ROOT_W;

   // distance ramp: (center - d) / span, tabulated over d < center
   localparam int DIST_CENTER = 80;
   localparam int DIST_SPAN   = 160;
   localparam int DIST_IDX_W  = $clog2(DIST_CENTER);

   // heading ramp: (half turn - |e|) / half turn, half turn = 2^HEAD_SHIFT * HEAD_DIV
   localparam int unsigned HEAD_HALF_TURN = 11520;
   localparam int          HEAD_SHIFT     = 8;
   localparam int unsigned HEAD_DIV       = HEAD_HALF_TURN >> HEAD_SHIFT;
   localparam int          N_W            = $clog2(HEAD_HALF_TURN + 1);
   localparam int          Y_W            = N_W + FRAC_BITS - HEAD_SHIFT;

   // reciprocal of the heading divisor, scaled by 2^Y_W (truncated, so the
   // quotient estimate is low by at most one)
   localparam logic [Y_W-1:0] HEAD_RECIP = Y_W'((longint'(1) << Y_W) / HEAD_DIV);

   typedef logic [MEM_W-1:0] dist_lut_type [DIST_CENTER];

   function automatic dist_lut_type build_dist_lut();
      dist_lut_type lut;
      for (int i = 0; i < DIST_CENTER; i++) begin
         lut[i] = MEM_W'((longint'(DIST_CENTER - i) << FRAC_BITS) / DIST_SPAN);
      end
      return lut;
   endfunction

   localparam dist_lut_type DIST_LUT = build_dist_lut();

   // word handed from cell to cell
   typedef struct packed {
      logic        [SUM_W-1:0]  rad;
      logic        [REM_W-1:0]  rem;
      logic        [ROOT_W-1:0] root;
      logic signed [HERR_W-1:0] herr;
      logic        [Y_W-1:0]    head_num;
      logic        [MEM_W-1:0]  head_quot;
   } cell_data_type;

endpackage

>>> rtl/tef_if.sv
// ----------------------------------------------------------------------------
// tef_if - request and response channels of the tracking error fuzzifier
// Valid/ready channels; a transaction moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface tef_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [tef_pkg::POS_BITS-1:0]  ref_x;
   logic signed [tef_pkg::POS_BITS-1:0]  ref_y;
   logic signed [tef_pkg::HEAD_BITS-1:0] ref_heading;
   logic signed [tef_pkg::POS_BITS-1:0]  robot_x;
   logic signed [tef_pkg::POS_BITS-1:0]  robot_y;
   logic signed [tef_pkg::HEAD_BITS-1:0] robot_heading;

   modport source (
      output valid, ref_x, ref_y, ref_heading, robot_x, robot_y, robot_heading,
      input  ready
   );
   modport sink (
      input  valid, ref_x, ref_y, ref_heading, robot_x, robot_y, robot_heading,
      output ready
   );
endinterface

interface tef_rsp_if;
   logic                             valid;
   logic                             ready;
   logic        [tef_pkg::DIST_W-1:0] distance_error;
   logic signed [tef_pkg::HERR_W-1:0] heading_error;
   logic        [tef_pkg::MEM_W-1:0]  dist_small;
   logic        [tef_pkg::MEM_W-1:0]  dist_large;
   logic        [tef_pkg::MEM_W-1:0]  head_small;
   logic        [tef_pkg::MEM_W-1:0]  head_large;

   modport source (
      output valid, distance_error, heading_error, dist_small, dist_large,
             head_small, head_large,
      input  ready
   );
   modport sink (
      input  valid, distance_error, heading_error, dist_small, dist_large,
             head_small, head_large,
      output ready
   );
endinterface

>>> rtl/tef_front.sv
// ----------------------------------------------------------------------------
// tef_front - error forming and squaring stages
// Stage one forms |dx|, |dy|, the heading error and the heading ramp numerator;
// stage two squares and sums the offsets and estimates the heading quotient.
// ----------------------------------------------------------------------------
module tef_front (
   input  logic                   clock,
   input  logic                   reset,
   tef_req_if.sink                req,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tef_pkg::cell_data_type out_data
);

   typedef struct packed {
      logic        [tef_pkg::POS_BITS-1:0] dx;
      logic        [tef_pkg::POS_BITS-1:0] dy;
      logic signed [tef_pkg::HERR_W-1:0]   herr;
      logic        [tef_pkg::Y_W-1:0]      head_num;
   } err_type;

   logic    a_valid_ff;
   logic    a_ready;
   err_type a_in;
   err_type a_ff;
   logic    b_valid_ff;
   logic    b_ready;
   tef_pkg::cell_data_type b_in;
   tef_pkg::cell_data_type b_ff;

   logic signed [tef_pkg::POS_BITS:0]     diff_x;
   logic signed [tef_pkg::POS_BITS:0]     diff_y;
   logic        [tef_pkg::HERR_W-1:0]     habs;
   logic        [tef_pkg::N_W-1:0]        head_rest;
   logic        [2*tef_pkg::POS_BITS-1:0] sq_x;
   logic        [2*tef_pkg::POS_BITS-1:0] sq_y;
   logic        [2*tef_pkg::Y_W-1:0]      head_prod;

   // stage handshakes
   assign a_ready   = !a_valid_ff || b_ready;
   assign b_ready   = !b_valid_ff || out_ready;
   assign req.ready = a_ready;
   assign out_valid = b_valid_ff;
   assign out_data  = b_ff;

   // offsets and heading error
   always_comb begin
      diff_x  = (tef_pkg::POS_BITS+1)'(req.ref_x) - (tef_pkg::POS_BITS+1)'(req.robot_x);
      diff_y  = (tef_pkg::POS_BITS+1)'(req.ref_y) - (tef_pkg::POS_BITS+1)'(req.robot_y);
      a_in.dx = diff_x[tef_pkg::POS_BITS] ? tef_pkg::POS_BITS'(-diff_x)
                                          : tef_pkg::POS_BITS'(diff_x);
      a_in.dy = diff_y[tef_pkg::POS_BITS] ? tef_pkg::POS_BITS'(-diff_y)
                                          : tef_pkg::POS_BITS'(diff_y);
      a_in.herr = tef_pkg::HERR_W'(req.ref_heading) - tef_pkg::HERR_W'(req.robot_heading);
      habs      = a_in.herr[tef_pkg::HERR_W-1] ? tef_pkg::HERR_W'(-a_in.herr)
                                               : tef_pkg::HERR_W'(a_in.herr);
      // clamp: beyond a half turn the small heading ramp is zero
      if (32'(habs) < tef_pkg::HEAD_HALF_TURN) begin
         head_rest = tef_pkg::N_W'(tef_pkg::HEAD_HALF_TURN - 32'(habs));
      end else begin
         head_rest = '0;
      end
      a_in.head_num = tef_pkg::Y_W'(head_rest) << (tef_pkg::FRAC_BITS - tef_pkg::HEAD_SHIFT);
   end

   // squares and quotient estimate
   always_comb begin
      sq_x      = a_ff.dx * a_ff.dx;
      sq_y      = a_ff.dy * a_ff.dy;
      head_prod = (2*tef_pkg::Y_W)'(a_ff.head_num) * (2*tef_pkg::Y_W)'(tef_pkg::HEAD_RECIP);
      b_in.rad       = tef_pkg::SUM_W'(sq_x) + tef_pkg::SUM_W'(sq_y);
      b_in.rem       = '0;
      b_in.root      = '0;
      b_in.herr      = a_ff.herr;
      b_in.head_num  = a_ff.head_num;
      b_in.head_quot = head_prod[tef_pkg::Y_W +: tef_pkg::MEM_W];
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= req.valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (a_ready && req.valid) a_ff <= a_in;
      if (b_ready && a_valid_ff) b_ff <= b_in;
   end

endmodule

>>> rtl/tef_cell.sv
// ----------------------------------------------------------------------------
// tef_cell - one digit of the integer square root
// Shifts two radicand bits into the remainder, tries root*4+1 against it and
// appends one root bit; the side payload passes along unchanged.
// ----------------------------------------------------------------------------
module tef_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tef_pkg::cell_data_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tef_pkg::cell_data_type out_data
);

   logic                         valid_ff;
   tef_pkg::cell_data_type       data_in;
   tef_pkg::cell_data_type       data_ff;
   logic [tef_pkg::REM_W-1:0]    rem_shift;
   logic [tef_pkg::REM_W-1:0]    trial;
   logic                         fits;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // restoring digit step
   always_comb begin
      rem_shift = {in_data.rem[tef_pkg::REM_W-3:0],
                   in_data.rad[tef_pkg::SUM_W-1 -: 2]};
      trial     = {in_data.root, 2'b01};
      fits      = rem_shift >= trial;
      data_in      = in_data;
      data_in.rad  = in_data.rad << 2;
      data_in.rem  = fits ? rem_shift - trial : rem_shift;
      data_in.root = {in_data.root[tef_pkg::ROOT_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) data_ff <= data_in;
   end

endmodule

>>> rtl/tef_tail.sv
// ----------------------------------------------------------------------------
// tef_tail - membership stage and response register
// Looks up the distance ramp, corrects the heading quotient estimate, forms
// the complements and holds the result on the response channel.
// ----------------------------------------------------------------------------
module tef_tail (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tef_pkg::cell_data_type in_data,
   tef_rsp_if.source              rsp
);

   typedef struct packed {
      logic        [tef_pkg::DIST_W-1:0] distance_error;
      logic signed [tef_pkg::HERR_W-1:0] heading_error;
      logic        [tef_pkg::MEM_W-1:0]  dist_small;
      logic        [tef_pkg::MEM_W-1:0]  dist_large;
      logic        [tef_pkg::MEM_W-1:0]  head_small;
      logic        [tef_pkg::MEM_W-1:0]  head_large;
   } result_type;

   logic                      valid_ff;
   result_type                result_in;
   result_type                result_ff;
   logic [tef_pkg::Y_W-1:0]   quot_times_div;
   logic [tef_pkg::Y_W-1:0]   resid;
   logic [tef_pkg::MEM_W-1:0] ds;
   logic [tef_pkg::MEM_W-1:0] hs;

   assign in_ready = !valid_ff || rsp.ready;
   assign rsp.valid          = valid_ff;
   assign rsp.distance_error = result_ff.distance_error;
   assign rsp.heading_error  = result_ff.heading_error;
   assign rsp.dist_small     = result_ff.dist_small;
   assign rsp.dist_large     = result_ff.dist_large;
   assign rsp.head_small     = result_ff.head_small;
   assign rsp.head_large     = result_ff.head_large;

   // memberships
   always_comb begin
      if (32'(in_data.root) < tef_pkg::DIST_CENTER) begin
         ds = tef_pkg::DIST_LUT[in_data.root[tef_pkg::DIST_IDX_W-1:0]];
      end else begin
         ds = '0;
      end
      // estimate is low by at most one: one compare fixes it
      quot_times_div = tef_pkg::Y_W'(tef_pkg::Y_W'(in_data.head_quot) *
                                     tef_pkg::Y_W'(tef_pkg::HEAD_DIV));
      resid = in_data.head_num - quot_times_div;
      hs    = in_data.head_quot +
              tef_pkg::MEM_W'(32'(resid) >= tef_pkg::HEAD_DIV);
      result_in.distance_error = in_data.root;
      result_in.heading_error  = in_data.herr;
      result_in.dist_small     = ds;
      result_in.dist_large     = tef_pkg::ONE - ds;
      result_in.head_small     = hs;
      result_in.head_large     = tef_pkg::ONE - hs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) result_ff <= result_in;
   end

endmodule

>>> rtl/tracking_error_fuzzifier_core.sv
// ----------------------------------------------------------------------------
// tracking_error_fuzzifier_core - fuzzification of pose tracking errors
// Takes a reference and a measured pose per request transaction and returns
// the distance and heading errors with their small and large memberships.
//
// Usage:
//   req carries ref_x/ref_y/ref_heading and robot_x/robot_y/robot_heading;
//   rsp carries distance_error, heading_error and four Q1.15 memberships.
//   Every request gives exactly one response, in order.
// Stages: 20 register stages between request and response: two front
//   stages, one cell per root bit (17 cells) and the response register.
// Throughput: one transaction per cycle; every stage is a register with its
//   own valid, so the cell chain takes a new item each cycle unless stalled.
// Stall: when rsp.ready is low the response register holds and stages behind
//   it fill up; empty stages keep taking requests until the chain is full,
//   then req.ready drops. Nothing is lost or repeated.
// Reset: synchronous, clears all stage valids; the block is ready the cycle
//   after reset is released.
// ----------------------------------------------------------------------------
module tracking_error_fuzzifier_core (
   input  logic      clock,
   input  logic      reset,
   tef_req_if.sink   req,
   tef_rsp_if.source rsp
);

   logic                   chain_valid [tef_pkg::NUM_CELLS+1];
   logic                   chain_ready [tef_pkg::NUM_CELLS+1];
   tef_pkg::cell_data_type chain_data  [tef_pkg::NUM_CELLS+1];

   // error forming and squaring
   tef_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // square root cell chain, one root bit per cell
   for (genvar k = 0; k < tef_pkg::NUM_CELLS; k++) begin : g_cell
      tef_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   // memberships and response register
   tef_tail u_tail (
      .clock    (clock),
      .reset    (reset),
      .in_valid (chain_valid[tef_pkg::NUM_CELLS]),
      .in_ready (chain_ready[tef_pkg::NUM_CELLS]),
      .in_data  (chain_data[tef_pkg::NUM_CELLS]),
      .rsp      (rsp)
   );

endmodule

>>> rtl/tef_checker.sv
// ----------------------------------------------------------------------------
// tef_checker - port-level checks of the tracking error fuzzifier
// Watches for held transactions, complementary memberships, a zero small
// distance membership past the ramp center and a quiet output after reset.
// ----------------------------------------------------------------------------
module tef_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic        [tef_pkg::DIST_W-1:0] rsp_distance_error,
   input logic signed [tef_pkg::HERR_W-1:0] rsp_heading_error,
   input logic        [tef_pkg::MEM_W-1:0]  rsp_dist_small,
   input logic        [tef_pkg::MEM_W-1:0]  rsp_dist_large,
   input logic        [tef_pkg::MEM_W-1:0]  rsp_head_small,
   input logic        [tef_pkg::MEM_W-1:0]  rsp_head_large
);

   // stalled response stays valid; its errors and small memberships hold
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance_error) &&
      $stable(rsp_heading_error) && $stable(rsp_dist_small) && $stable(rsp_head_small))
      else $error("stalled response changed");

   // distance memberships are complements
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (tef_pkg::MEM_W+1)'(rsp_dist_small) + (tef_pkg::MEM_W+1)'(rsp_dist_large)
                    == (tef_pkg::MEM_W+1)'(tef_pkg::ONE))
      else $error("distance memberships do not sum to one");

   // heading memberships are complements
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (tef_pkg::MEM_W+1)'(rsp_head_small) + (tef_pkg::MEM_W+1)'(rsp_head_large)
                    == (tef_pkg::MEM_W+1)'(tef_pkg::ONE))
      else $error("heading memberships do not sum to one");

   // no small distance membership past the ramp center
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (32'(rsp_distance_error) >= tef_pkg::DIST_CENTER) |-> rsp_dist_small == '0)
      else $error("small distance membership past ramp");

   // response channel is empty after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind tracking_error_fuzzifier_core tef_checker u_tef_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_distance_error (rsp.distance_error),
   .rsp_heading_error  (rsp.heading_error),
   .rsp_dist_small     (rsp.dist_small),
   .rsp_dist_large     (rsp.dist_large),
   .rsp_head_small     (rsp.head_small),
   .rsp_head_large     (rsp.head_large)
);
